FILE: hw/rtl/ffscd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffscd_pkg: shared types and constants of the checksum deframer
// Byte widths, header reset value, readout state type and frame queue status.
// ----------------------------------------------------------------------------
package ffscd_pkg;

   localparam int BYTE_W = 8;
   localparam int INDEX_W = 5;
   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

   // readout sequencer of the back end
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_SEND
   } back_state_type;

   // status of the queue of checked frames waiting for readout
   typedef struct packed {
      logic empty;
      logic full;
      logic head_bank;
   } fq_status_type;

endpackage : ffscd_pkg
`default_nettype wire

FILE: hw/rtl/ffscd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffscd_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffscd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : ffscd_ram
`default_nettype wire

FILE: hw/rtl/ffscd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffscd_front: header detect, frame fill and checksum check
// Stores armed bytes into the current bank and posts passing frames.
// ----------------------------------------------------------------------------
module ffscd_front
   import ffscd_pkg::*;
#(
   parameter int FRAME_BYTES = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [BYTE_W-1:0]               csr_wr_data,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [BYTE_W-1:0]               req_tdata,
   input  wire fq_status_type                   fq_status,
   output logic                                 frame_push,
   output logic                                 wr_en,
   output logic [$clog2(FRAME_BYTES):0]         wr_addr,
   output logic [BYTE_W-1:0]                    wr_data
);

   localparam int AW = $clog2(FRAME_BYTES);
   localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);

   logic [BYTE_W-1:0] header_ff, header_in;
   logic              armed_ff, armed_in;
   logic [AW-1:0]     count_ff, count_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic              bank_ff, bank_in;
   logic              accept, is_header, store;

   // both banks held by the back end: hold off new bytes
   assign req_tready = !fq_status.full;
   assign accept     = req_tvalid && req_tready;
   assign is_header  = (req_tdata == header_ff);
   assign store      = accept && !is_header && armed_ff;

   assign wr_en   = store;
   assign wr_addr = {bank_ff, count_ff};
   assign wr_data = req_tdata;

   always_comb begin
      header_in  = csr_wr_en ? csr_wr_data : header_ff;
      armed_in   = armed_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      bank_in    = bank_ff;
      frame_push = 1'b0;
      if (accept && is_header) begin
         armed_in = 1'b1;
      end else if (store) begin
         if (count_ff == LAST_IDX) begin
            frame_push = (sum_ff == req_tdata);
            bank_in    = bank_ff ^ frame_push;
            armed_in   = 1'b0;
            count_in   = '0;
            sum_in     = '0;
         end else begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         armed_ff  <= 1'b0;
         count_ff  <= '0;
         sum_ff    <= '0;
         bank_ff   <= 1'b0;
      end else begin
         header_ff <= header_in;
         armed_ff  <= armed_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         bank_ff   <= bank_in;
      end
   end

endmodule : ffscd_front
`default_nettype wire

FILE: hw/rtl/ffscd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffscd_queue: two-entry queue of checked frames
// Banks alternate, so an occupancy count and the head bank suffice.
// ----------------------------------------------------------------------------
module ffscd_queue
   import ffscd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire logic    pop,
   output fq_status_type status
);

   logic [1:0] count_ff, count_in;
   logic       head_ff, head_in;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      head_in  = head_ff ^ pop;
   end

   assign status.empty     = (count_ff == 2'd0);
   assign status.full      = (count_ff == 2'd2);
   assign status.head_bank = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2))
      else $error("frame pushed while both banks busy");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != 2'd0))
      else $error("frame popped from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_head_moves_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> (head_ff != $past(head_ff)))
      else $error("head bank did not advance");

endmodule : ffscd_queue
`default_nettype wire

FILE: hw/rtl/ffscd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffscd_back: frame readout
// Reads a checked frame from its bank and sends it byte by byte.
// ----------------------------------------------------------------------------
module ffscd_back
   import ffscd_pkg::*;
#(
   parameter int FRAME_BYTES = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire fq_status_type            fq_status,
   output logic                          frame_pop,
   output logic                          rd_en,
   output logic [$clog2(FRAME_BYTES):0]  rd_addr,
   input  wire logic [BYTE_W-1:0]        rd_data,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [15:0]                   rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int AW = $clog2(FRAME_BYTES);
   localparam int IXW = (AW > INDEX_W) ? AW : INDEX_W;
   localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);

   back_state_type state_ff, state_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic [IXW-1:0] idx_wide;
   logic           sent, at_last;

   assign at_last  = (idx_ff == LAST_IDX);
   assign sent     = (state_ff == BK_SEND) && rsp_tready;
   assign idx_wide = IXW'(idx_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!fq_status.empty) begin
               state_in = BK_FETCH;
            end
         end
         BK_FETCH: begin
            state_in = BK_SEND;
         end
         BK_SEND: begin
            if (rsp_tready) begin
               state_in = at_last ? BK_IDLE : BK_FETCH;
               idx_in   = at_last ? '0 : idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = BK_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   // outputs
   always_comb begin
      rd_en      = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         BK_FETCH: rd_en = 1'b1;
         BK_SEND:  rsp_tvalid = 1'b1;
         default: begin
            rd_en      = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   assign frame_pop = sent && at_last;
   assign rd_addr   = {fq_status.head_bank, idx_ff};
   assign rsp_tdata = {3'b000, idx_wide[INDEX_W-1:0], rd_data};
   assign rsp_tlast = at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   a_send_after_fetch: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(rd_en))
      else $error("byte shown without a RAM read");

   a_readout_needs_frame: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !fq_status.empty)
      else $error("RAM read with no frame queued");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while stalled");

endmodule : ffscd_back
`default_nettype wire

FILE: hw/rtl/fixed_frame_sum_checksum_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_frame_sum_checksum_deframer: fixed-length frame receiver, sum8 check
// Header-armed byte capture with additive checksum and checked-frame replay.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one received byte per request. A byte equal to the header value
//    arms the receiver and is dropped (also in mid-frame, count and sum kept).
//    Armed bytes are stored until FRAME_BYTES are in; the last one must equal
//    the 8-bit sum of the others, otherwise the frame is dropped silently.
//  - rsp_*: a passing frame is replayed in order, one byte per request,
//    with its position in tdata and tlast on the final byte.
//  - csr_*: header value, reset 0xAA; write only while idle.
//  - Flow: the front takes one request per cycle while req_tready is high.
//    Readout reads each byte from the RAM, then sends it, and returns to idle
//    to pick up the next frame; at the earliest, a checked frame is shown
//    after its push into the queue, the fetch state and the RAM read.
//  - The RAM holds two banks: one filling, one replaying. If both hold
//    frames waiting for readout, req_tready drops until a bank is freed.
//  - A stalled rsp side holds its byte and, after two frames, stalls req.
//  - Reset: synchronous; disarms, clears count, sum and queue. No RAM clear.
// ----------------------------------------------------------------------------
module fixed_frame_sum_checksum_deframer
   import ffscd_pkg::*;
#(
   parameter int FRAME_BYTES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,   // header_value
   // received bytes
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,     // [7:0] rx_byte
   // checked frame bytes
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,     // [7:0] frame_byte, [12:8] byte_index
   output logic             rsp_tlast      // last_byte
);

   localparam int AW = $clog2(FRAME_BYTES);
   localparam int RAM_DEPTH = 2 << AW;   // two banks of 2**AW entries

   fq_status_type     fq_status;
   logic              frame_push, frame_pop;
   logic              wr_en, rd_en;
   logic [AW:0]       wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data;

   // front: header, fill, checksum
   ffscd_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .fq_status   (fq_status),
      .frame_push  (frame_push),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   // queue of checked frames between front and back
   ffscd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (frame_push),
      .pop    (frame_pop),
      .status (fq_status)
   );

   // double-banked frame store
   ffscd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // back: frame replay
   ffscd_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fq_status  (fq_status),
      .frame_pop  (frame_pop),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule : fixed_frame_sum_checksum_deframer
`default_nettype wire
